[rtl/ald_pkg.sv]
// Shared types, constants and the sine table builder for the landmark detector.
// Depends on nothing; every other file refers to it by scoped names.
package ald_pkg;

    // Table and trig sizes
    localparam int TABLE_ENTRIES      = 64;
    localparam int SINE_TABLE_ENTRIES = 256;
    localparam int ADDR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int SINE_W = $clog2(SINE_TABLE_ENTRIES);

    // Field widths
    localparam int COORD_W  = 24;  // signed Q16.8 position
    localparam int TRIG_W   = 16;  // signed Q1.14 sine / cosine
    localparam int LA_W     = 16;  // unsigned Q8.8 look-ahead
    localparam int MAXD_W   = 23;  // unsigned Q15.8 distance limit
    localparam int PROD_W   = 33;  // trig times look-ahead
    localparam int OFF_W    = 20;  // rounded offset, Q.8
    localparam int FX_W     = 25;  // look-ahead point coordinate
    localparam int DP_W     = 25;  // pose minus landmark
    localparam int DF_W     = 26;  // look-ahead point minus landmark
    localparam int SQP_W    = 50;
    localparam int SQF_W    = 52;
    localparam int DIST_W   = 52;  // squared distance
    localparam int LIMIT_W  = 46;  // squared distance limit

    // Configuration register indexes
    localparam logic CFG_LOOK_AHEAD = 1'b0;
    localparam logic CFG_MAX_DIST   = 1'b1;

    // Request codes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Kind that answers a fixed value instead of its label
    localparam logic [1:0] KIND_CROSSWALK = 2'd0;
    localparam logic [1:0] CROSSWALK_VALUE = 2'd1;

    // Polynomial coefficients of the quarter-wave sine, Q30
    localparam logic [63:0] POLY_A = 64'd1686629713;
    localparam logic [63:0] POLY_B = 64'd693598669;
    localparam logic [63:0] POLY_C = 64'd85569305;
    localparam logic [63:0] POLY_D = 64'd5026995;
    localparam logic [63:0] POLY_E = 64'd172273;

    typedef logic signed [TRIG_W-1:0] t_trig;
    typedef t_trig t_sine_rom [SINE_TABLE_ENTRIES];

    // One landmark as stored in the table memory
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [1:0]                kind;
        logic [1:0]                label;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TRIG,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_ald_state;

    // Sine over the first quadrant, argument in 0..16384, Q14 result
    function automatic logic [63:0] quarter_sine(input logic [63:0] x);
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] r;
        t  = x << 16;
        t2 = (t * t) >> 30;
        r  = POLY_E;
        r  = POLY_D - ((r * t2) >> 30);
        r  = POLY_C - ((r * t2) >> 30);
        r  = POLY_B - ((r * t2) >> 30);
        r  = POLY_A - ((r * t2) >> 30);
        r  = (r * t) >> 30;
        r  = (r + 64'd32768) >> 16;
        if (r > 64'd16384) begin
            r = 64'd16384;
        end
        return r;
    endfunction

    // Full sine table, evaluated at elaboration
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom   rom;
        logic [63:0] a;
        logic [63:0] q;
        logic [63:0] x;
        logic [63:0] s;
        for (int k = 0; k < SINE_TABLE_ENTRIES; k++) begin
            a = ((64'(k) * 64'd65536) / SINE_TABLE_ENTRIES) & 64'hFFFF;
            q = a >> 14;
            x = a & 64'd16383;
            if (q[0]) begin
                s = quarter_sine(64'd16384 - x);
            end else begin
                s = quarter_sine(x);
            end
            if (q[1]) begin
                rom[k] = t_trig'(-s);
            end else begin
                rom[k] = t_trig'(s);
            end
        end
        return rom;
    endfunction

endpackage

[rtl/ald_offset.sv]
// Look-ahead point unit: sine/cosine table lookup, scaling by the look-ahead
// distance and addition to the pose. Depends on ald_pkg.
module ald_offset (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    input  logic [15:0]                             i_heading,
    input  logic [ald_pkg::LA_W-1:0]                i_look_ahead,
    input  logic signed [ald_pkg::COORD_W-1:0]      i_pose_x,
    input  logic signed [ald_pkg::COORD_W-1:0]      i_pose_y,
    output logic                                    o_done,
    output logic signed [ald_pkg::FX_W-1:0]         o_fx,
    output logic signed [ald_pkg::FX_W-1:0]         o_fy
);

    localparam ald_pkg::t_sine_rom SINE_ROM = ald_pkg::build_sine_rom();

    logic [15:0]                         w_cos_angle;
    logic [31:0]                         w_sin_pos;
    logic [31:0]                         w_cos_pos;
    logic [ald_pkg::SINE_W-1:0]          w_sin_idx;
    logic [ald_pkg::SINE_W-1:0]          w_cos_idx;
    logic signed [ald_pkg::PROD_W-1:0]   n_prod_x;
    logic signed [ald_pkg::PROD_W-1:0]   n_prod_y;
    logic signed [ald_pkg::PROD_W:0]     w_rnd_x;
    logic signed [ald_pkg::PROD_W:0]     w_rnd_y;
    logic signed [ald_pkg::OFF_W-1:0]    w_off_x;
    logic signed [ald_pkg::OFF_W-1:0]    w_off_y;
    logic signed [ald_pkg::FX_W-1:0]     n_fx;
    logic signed [ald_pkg::FX_W-1:0]     n_fy;

    ald_pkg::t_trig                      r_sin;
    ald_pkg::t_trig                      r_cos;
    logic signed [ald_pkg::PROD_W-1:0]   r_prod_x;
    logic signed [ald_pkg::PROD_W-1:0]   r_prod_y;
    logic signed [ald_pkg::FX_W-1:0]     r_fx;
    logic signed [ald_pkg::FX_W-1:0]     r_fy;
    logic                                r_v1;
    logic                                r_v2;
    logic                                r_v3;

    // Map the binary angle onto the table: floor(angle * entries / 65536)
    assign w_cos_angle = i_heading + 16'd16384;
    assign w_sin_pos   = 32'(i_heading) * 32'(ald_pkg::SINE_TABLE_ENTRIES);
    assign w_cos_pos   = 32'(w_cos_angle) * 32'(ald_pkg::SINE_TABLE_ENTRIES);
    assign w_sin_idx   = w_sin_pos[16 +: ald_pkg::SINE_W];
    assign w_cos_idx   = w_cos_pos[16 +: ald_pkg::SINE_W];

    // Scale trig by the look-ahead distance (Q14 x Q8.8 = Q22)
    assign n_prod_x = ald_pkg::PROD_W'(r_cos)
                    * ald_pkg::PROD_W'(signed'({1'b0, i_look_ahead}));
    assign n_prod_y = ald_pkg::PROD_W'(r_sin)
                    * ald_pkg::PROD_W'(signed'({1'b0, i_look_ahead}));

    // Round to Q.8, ties toward plus infinity, then add to the pose
    assign w_rnd_x = (ald_pkg::PROD_W+1)'(r_prod_x) + (ald_pkg::PROD_W+1)'(8192);
    assign w_rnd_y = (ald_pkg::PROD_W+1)'(r_prod_y) + (ald_pkg::PROD_W+1)'(8192);
    assign w_off_x = signed'(w_rnd_x[ald_pkg::PROD_W -: ald_pkg::OFF_W]);
    assign w_off_y = signed'(w_rnd_y[ald_pkg::PROD_W -: ald_pkg::OFF_W]);
    assign n_fx    = ald_pkg::FX_W'(i_pose_x) + ald_pkg::FX_W'(w_off_x);
    assign n_fy    = ald_pkg::FX_W'(i_pose_y) + ald_pkg::FX_W'(w_off_y);

    // Stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Stage data: table read, product, sum
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sin <= SINE_ROM[w_sin_idx];
            r_cos <= SINE_ROM[w_cos_idx];
        end
        if (r_v1) begin
            r_prod_x <= n_prod_x;
            r_prod_y <= n_prod_y;
        end
        if (r_v2) begin
            r_fx <= n_fx;
            r_fy <= n_fy;
        end
    end

    assign o_done = r_v3;
    assign o_fx   = r_fx;
    assign o_fy   = r_fy;

endmodule

[rtl/approaching_landmark_detector.sv]
// Top level of the approaching-landmark detector: landmark table memory,
// scan pipeline, sequencer and stream ports. Depends on ald_pkg, ald_offset.
//
// Usage: items arrive on the s_axis channel, one result per item leaves on
// m_axis. tuser selects the request: 0 loads or clears one table slot, 1 runs
// a query for the pose and kind in tdata. The result tuser is the detected
// flag; tdata carries the value and the slot of the chosen landmark.
// A load result is loaded straight into the output register. A query runs
// the sine lookup and offset, one memory read per table slot, the drain of
// the distance pipeline and the load of the output register. The next item
// can be taken once the result is in the output register. The scan of the
// table memory sets the rate; one item is worked on at a time.
// A finished result sits in the output register; the next item is taken
// while it waits. If the receiver still stalls when the next result is done,
// the block holds that result and takes no new item.
// Reset clears all valid marks and the output valid flag and loads the
// registers with look_ahead 256 and max_distance 1280; there is no clearing
// pass. Configuration writes go through i_cfg_we / i_cfg_idx / i_cfg_data.
module approaching_landmark_detector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [22:0] i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // slot[5:0], feature_kind[7:6], entry_enable[8], entry_label[10:9],
    // point_x[34:11], point_y[58:35], heading[74:59], zero fill [79:75]
    input  logic [79:0] s_axis_tdata,
    // req_type[0]
    input  logic        s_axis_tuser,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // feature_value[1:0], match_slot[7:2]
    output logic [7:0]  m_axis_tdata,
    // detected[0]
    output logic        m_axis_tuser
);

    localparam int AW = ald_pkg::ADDR_W;

    // Input field unpacking
    logic [5:0]                          w_in_slot;
    logic [1:0]                          w_in_kind;
    logic                                w_in_enable;
    logic [1:0]                          w_in_label;
    logic signed [ald_pkg::COORD_W-1:0]  w_in_x;
    logic signed [ald_pkg::COORD_W-1:0]  w_in_y;
    logic [15:0]                         w_in_heading;

    assign w_in_slot    = s_axis_tdata[5:0];
    assign w_in_kind    = s_axis_tdata[7:6];
    assign w_in_enable  = s_axis_tdata[8];
    assign w_in_label   = s_axis_tdata[10:9];
    assign w_in_x       = signed'(s_axis_tdata[34:11]);
    assign w_in_y       = signed'(s_axis_tdata[58:35]);
    assign w_in_heading = s_axis_tdata[74:59];

    ald_pkg::t_ald_state r_state;
    ald_pkg::t_ald_state n_state;

    logic w_accept;
    logic w_load_hit;
    logic w_start;
    logic w_issue;
    logic w_scan_last;
    logic w_pipe_busy;
    logic w_out_free;
    logic w_out_load;
    logic w_trig_done;

    // Configuration registers
    logic [ald_pkg::LA_W-1:0]   r_look_ahead;
    logic [ald_pkg::MAXD_W-1:0] r_max_dist;
    logic [ald_pkg::LIMIT_W-1:0] r_limit;

    // Query registers
    logic [1:0]                          r_q_kind;
    logic signed [ald_pkg::COORD_W-1:0]  r_q_x;
    logic signed [ald_pkg::COORD_W-1:0]  r_q_y;
    logic [15:0]                         r_q_heading;
    logic signed [ald_pkg::FX_W-1:0]     w_fx;
    logic signed [ald_pkg::FX_W-1:0]     w_fy;

    // Table storage
    ald_pkg::t_entry r_table [ald_pkg::TABLE_ENTRIES];
    logic [ald_pkg::TABLE_ENTRIES-1:0] r_valid;
    logic [AW-1:0]   w_wr_addr;
    logic [AW-1:0]   r_scan_cnt;

    // Read stage
    logic            r_rd_live;
    logic            r_rd_vbit;
    logic [AW-1:0]   r_rd_slot;
    ald_pkg::t_entry r_rd_entry;

    // Difference stage
    logic                               r_d_live;
    logic                               r_d_ok;
    logic [AW-1:0]                      r_d_slot;
    logic [1:0]                         r_d_label;
    logic signed [ald_pkg::DP_W-1:0]    r_dpx;
    logic signed [ald_pkg::DP_W-1:0]    r_dpy;
    logic signed [ald_pkg::DF_W-1:0]    r_dfx;
    logic signed [ald_pkg::DF_W-1:0]    r_dfy;

    // Square stage
    logic                        r_m_live;
    logic                        r_m_ok;
    logic [AW-1:0]               r_m_slot;
    logic [1:0]                  r_m_label;
    logic [ald_pkg::SQP_W-1:0]   r_sq_px;
    logic [ald_pkg::SQP_W-1:0]   r_sq_py;
    logic [ald_pkg::SQF_W-1:0]   r_sq_fx;
    logic [ald_pkg::SQF_W-1:0]   r_sq_fy;

    // Sum stage
    logic                        r_s_live;
    logic                        r_s_ok;
    logic [AW-1:0]               r_s_slot;
    logic [1:0]                  r_s_label;
    logic [ald_pkg::DIST_W-1:0]  r_dp;
    logic [ald_pkg::DIST_W-1:0]  r_df;

    // Running best
    logic                        r_found;
    logic [ald_pkg::DIST_W-1:0]  r_best;
    logic [AW-1:0]               r_best_slot;
    logic [1:0]                  r_best_label;
    logic                        w_take;

    // Output register
    logic        r_out_valid;
    logic        r_out_det;
    logic [1:0]  r_out_value;
    logic [5:0]  r_out_slot;
    logic        w_det;

    // Handshake and control decode
    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_wr_addr   = AW'(w_in_slot);
    assign w_load_hit  = w_accept && (s_axis_tuser == ald_pkg::REQ_LOAD)
                      && (32'(w_in_slot) < 32'(ald_pkg::TABLE_ENTRIES));
    assign w_scan_last = (32'(r_scan_cnt) == 32'(ald_pkg::TABLE_ENTRIES - 1));
    assign w_pipe_busy = r_rd_live || r_d_live || r_m_live || r_s_live;
    assign w_out_free  = !r_out_valid || m_axis_tready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ald_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = (s_axis_tuser == ald_pkg::REQ_QUERY) ? ald_pkg::S_TRIG
                                                                   : ald_pkg::S_DONE;
                end
            end
            ald_pkg::S_TRIG: begin
                if (w_trig_done) n_state = ald_pkg::S_SCAN;
            end
            ald_pkg::S_SCAN: begin
                if (w_scan_last) n_state = ald_pkg::S_DRAIN;
            end
            ald_pkg::S_DRAIN: begin
                if (!w_pipe_busy) n_state = ald_pkg::S_DONE;
            end
            ald_pkg::S_DONE: begin
                if (w_out_free) n_state = ald_pkg::S_IDLE;
            end
            default: n_state = ald_pkg::S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_axis_tready = (r_state == ald_pkg::S_IDLE);
        w_issue       = (r_state == ald_pkg::S_SCAN);
        w_out_load    = (r_state == ald_pkg::S_DONE) && w_out_free;
        w_start       = (r_state == ald_pkg::S_IDLE) && s_axis_tvalid
                     && (s_axis_tuser == ald_pkg::REQ_QUERY);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ald_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_look_ahead <= ald_pkg::LA_W'(256);
            r_max_dist   <= ald_pkg::MAXD_W'(1280);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ald_pkg::CFG_LOOK_AHEAD: r_look_ahead <= i_cfg_data[ald_pkg::LA_W-1:0];
                ald_pkg::CFG_MAX_DIST:   r_max_dist   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Squared distance limit, refreshed every cycle
    always_ff @(posedge i_clk) begin
        r_limit <= ald_pkg::LIMIT_W'(r_max_dist) * ald_pkg::LIMIT_W'(r_max_dist);
    end

    // Capture the query pose
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_q_kind    <= w_in_kind;
            r_q_x       <= w_in_x;
            r_q_y       <= w_in_y;
            r_q_heading <= w_in_heading;
        end
    end

    // Heading is taken at the transfer; the pose is added in the sum stage, after the table read and product stages
    ald_offset u_offset (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_start),
        .i_heading    (w_in_heading),
        .i_look_ahead (r_look_ahead),
        .i_pose_x     (r_q_x),
        .i_pose_y     (r_q_y),
        .o_done       (w_trig_done),
        .o_fx         (w_fx),
        .o_fy         (w_fy)
    );

    // Table memory: written by loads in idle, read at the scan counter address on every clock
    always_ff @(posedge i_clk) begin
        if (w_load_hit && w_in_enable) begin
            r_table[w_wr_addr] <= '{x: w_in_x, y: w_in_y, kind: w_in_kind,
                                    label: w_in_label};
        end
        r_rd_entry <= r_table[r_scan_cnt];
    end

    // Valid marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_load_hit) begin
            r_valid[w_wr_addr] <= w_in_enable;
        end
    end

    // Scan address counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_cnt <= '0;
        end else if (w_issue) begin
            r_scan_cnt <= w_scan_last ? '0 : r_scan_cnt + AW'(1);
        end
    end

    // Pipeline occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_live <= 1'b0;
            r_d_live  <= 1'b0;
            r_m_live  <= 1'b0;
            r_s_live  <= 1'b0;
            r_d_ok    <= 1'b0;
            r_m_ok    <= 1'b0;
            r_s_ok    <= 1'b0;
        end else begin
            r_rd_live <= w_issue;
            r_d_live  <= r_rd_live;
            r_m_live  <= r_d_live;
            r_s_live  <= r_m_live;
            r_d_ok    <= r_rd_live && r_rd_vbit && (r_rd_entry.kind == r_q_kind);
            r_m_ok    <= r_d_live && r_d_ok;
            r_s_ok    <= r_m_live && r_m_ok;
        end
    end

    // Pipeline data: read, differences, squares, sums
    always_ff @(posedge i_clk) begin
        r_rd_vbit <= r_valid[r_scan_cnt];
        r_rd_slot <= r_scan_cnt;

        r_d_slot  <= r_rd_slot;
        r_d_label <= r_rd_entry.label;
        r_dpx     <= ald_pkg::DP_W'(r_q_x) - ald_pkg::DP_W'(r_rd_entry.x);
        r_dpy     <= ald_pkg::DP_W'(r_q_y) - ald_pkg::DP_W'(r_rd_entry.y);
        r_dfx     <= ald_pkg::DF_W'(w_fx) - ald_pkg::DF_W'(r_rd_entry.x);
        r_dfy     <= ald_pkg::DF_W'(w_fy) - ald_pkg::DF_W'(r_rd_entry.y);

        r_m_slot  <= r_d_slot;
        r_m_label <= r_d_label;
        r_sq_px   <= ald_pkg::SQP_W'(r_dpx) * ald_pkg::SQP_W'(r_dpx);
        r_sq_py   <= ald_pkg::SQP_W'(r_dpy) * ald_pkg::SQP_W'(r_dpy);
        r_sq_fx   <= ald_pkg::SQF_W'(r_dfx) * ald_pkg::SQF_W'(r_dfx);
        r_sq_fy   <= ald_pkg::SQF_W'(r_dfy) * ald_pkg::SQF_W'(r_dfy);

        r_s_slot  <= r_m_slot;
        r_s_label <= r_m_label;
        r_dp      <= ald_pkg::DIST_W'(r_sq_px) + ald_pkg::DIST_W'(r_sq_py);
        r_df      <= ald_pkg::DIST_W'(r_sq_fx) + ald_pkg::DIST_W'(r_sq_fy);
    end

    // Keep the nearest approached entry; strict compare lets the lower slot win
    assign w_take = r_s_live && r_s_ok && (r_df < r_dp) && (!r_found || (r_dp < r_best));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (w_accept) begin
            r_found <= 1'b0;
        end else if (w_take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_best       <= r_dp;
            r_best_slot  <= r_s_slot;
            r_best_label <= r_s_label;
        end
    end

    // Result: zero unless an approached entry lies within the limit
    assign w_det = r_found && (r_best <= ald_pkg::DIST_W'(r_limit));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_det <= w_det;
            if (w_det) begin
                r_out_value <= (r_q_kind == ald_pkg::KIND_CROSSWALK)
                             ? ald_pkg::CROSSWALK_VALUE : r_best_label;
                r_out_slot  <= 6'(r_best_slot);
            end else begin
                r_out_value <= 2'd0;
                r_out_slot  <= 6'd0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_det;
    assign m_axis_tdata  = {r_out_slot, r_out_value};

    // Checks on the sequencer and result register
    a_pipe_empty_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_pipe_busy)
        else $error("scan pipeline busy while taking a new item");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ald_pkg::S_DONE) && w_out_free |=> m_axis_tvalid)
        else $error("finished result not presented");

    a_no_detect_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata == 8'd0))
        else $error("result fields set without a detection");

    a_counter_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ald_pkg::S_SCAN) |-> (r_scan_cnt == '0))
        else $error("scan counter not rewound outside the scan");

    a_heading_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ald_pkg::S_TRIG) |=> $stable(r_q_heading))
        else $error("query heading changed during offset computation");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for approaching_landmark_detector: loads and queries
// on the input stream, answers predicted in SystemVerilog and checked in order.
// Depends on ald_pkg and the detector RTL only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 80;   // one full query scan plus margin

    localparam logic [1:0] KIND_TURN     = 2'd1;
    localparam logic [1:0] KIND_JUNCTION = 2'd2;
    localparam logic [1:0] KIND_SPARE    = 2'd3;
    localparam logic [1:0] LABEL_NONE    = 2'd0;
    localparam logic [1:0] LABEL_ONE     = 2'd1;
    localparam logic [1:0] LABEL_TWO     = 2'd2;
    localparam logic [1:0] LABEL_ODD     = 2'd3;
    localparam logic [15:0] HEAD_EAST    = 16'd0;
    localparam logic [15:0] HEAD_NE      = 16'd8192;
    localparam logic [15:0] HEAD_NORTH   = 16'd16384;
    localparam logic [15:0] HEAD_WEST    = 16'd32768;
    localparam logic [15:0] HEAD_SE      = 16'd57344;
    localparam int COORD_MIN = -8388608;
    localparam int COORD_MAX = 8388607;

    typedef struct {
        logic                               req;
        logic [5:0]                         slot;
        logic [1:0]                         kind;
        logic                               enable;
        logic [1:0]                         label;
        logic signed [ald_pkg::COORD_W-1:0] x;
        logic signed [ald_pkg::COORD_W-1:0] y;
        logic [15:0]                        heading;
    } t_landmark_item;

    typedef struct packed {
        logic       detected;
        logic [1:0] value;
        logic [5:0] slot;
    } t_landmark_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [22:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tuser;

    approaching_landmark_detector dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock: 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state: register copies, landmark memory, sine ROM
    logic [15:0]       la_setting   = 16'd256;
    logic [22:0]       maxd_setting = 23'd1280;
    longint            mark_x     [ald_pkg::TABLE_ENTRIES];
    longint            mark_y     [ald_pkg::TABLE_ENTRIES];
    logic [1:0]        mark_kind  [ald_pkg::TABLE_ENTRIES];
    logic [1:0]        mark_label [ald_pkg::TABLE_ENTRIES];
    bit                mark_valid [ald_pkg::TABLE_ENTRIES];
    longint            sine_q14   [ald_pkg::SINE_TABLE_ENTRIES];
    t_landmark_answer  detector_answers[$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    bit tx_idle_on     = 1'b0;
    bit rx_stall_on    = 1'b0;
    int stall_left     = 0;

    // Quarter-wave sine in Q14 from the odd polynomial, truncating Q30 products
    function automatic longint unsigned quarter_wave(input longint unsigned arg);
        longint unsigned t;
        longint unsigned t2;
        longint unsigned acc;
        t   = arg << 16;
        t2  = (t * t) >> 30;
        acc = ald_pkg::POLY_E;
        acc = ald_pkg::POLY_D - ((acc * t2) >> 30);
        acc = ald_pkg::POLY_C - ((acc * t2) >> 30);
        acc = ald_pkg::POLY_B - ((acc * t2) >> 30);
        acc = ald_pkg::POLY_A - ((acc * t2) >> 30);
        acc = (acc * t) >> 30;
        acc = (acc + 64'd32768) >> 16;
        return (acc > 64'd16384) ? 64'd16384 : acc;
    endfunction

    function automatic void fill_sine_rom();
        longint unsigned angle;
        longint unsigned quad;
        longint unsigned frac;
        longint          mag;
        for (int k = 0; k < ald_pkg::SINE_TABLE_ENTRIES; k++) begin
            angle = ((longint'(k) * 65536) / ald_pkg::SINE_TABLE_ENTRIES) & 64'hFFFF;
            quad  = angle >> 14;
            frac  = angle & 64'd16383;
            mag   = quad[0] ? longint'(quarter_wave(64'd16384 - frac))
                            : longint'(quarter_wave(frac));
            sine_q14[k] = quad[1] ? -mag : mag;
        end
    endfunction

    // Offset along one axis: trig (Q14) times look-ahead (Q8.8), rounded to Q.8
    function automatic longint axis_offset(input logic [15:0] angle);
        longint prod;
        prod = sine_q14[(longint'(angle) * ald_pkg::SINE_TABLE_ENTRIES) >> 16]
             * longint'(la_setting);
        return (prod + 8192) >>> 14;
    endfunction

    // Apply one item to the landmark memory and work out its answer
    function automatic t_landmark_answer detect_landmark(input t_landmark_item it);
        t_landmark_answer ans;
        longint fx;
        longint fy;
        longint px;
        longint py;
        longint dx;
        longint dy;
        longint pose_d2;
        longint ahead_d2;
        longint best_d2;
        longint limit_d2;
        int     best_slot;
        bit     found;
        ans = '0;
        if (it.req == ald_pkg::REQ_LOAD) begin
            if (it.enable) begin
                mark_x[it.slot]     = longint'(it.x);
                mark_y[it.slot]     = longint'(it.y);
                mark_kind[it.slot]  = it.kind;
                mark_label[it.slot] = it.label;
                mark_valid[it.slot] = 1'b1;
            end else begin
                mark_valid[it.slot] = 1'b0;
            end
            return ans;
        end
        px = longint'(it.x);
        py = longint'(it.y);
        fx = px + axis_offset(it.heading + 16'd16384);
        fy = py + axis_offset(it.heading);
        found     = 1'b0;
        best_d2   = 0;
        best_slot = 0;
        limit_d2  = longint'(maxd_setting) * longint'(maxd_setting);
        for (int i = 0; i < ald_pkg::TABLE_ENTRIES; i++) begin
            if (!mark_valid[i] || mark_kind[i] != it.kind) continue;
            dx = px - mark_x[i];
            dy = py - mark_y[i];
            pose_d2 = dx * dx + dy * dy;
            if (found && pose_d2 >= best_d2) continue;
            dx = fx - mark_x[i];
            dy = fy - mark_y[i];
            ahead_d2 = dx * dx + dy * dy;
            if (ahead_d2 < pose_d2) begin
                found     = 1'b1;
                best_d2   = pose_d2;
                best_slot = i;
            end
        end
        if (found && best_d2 <= limit_d2) begin
            ans.detected = 1'b1;
            ans.value    = (it.kind == ald_pkg::KIND_CROSSWALK) ? ald_pkg::CROSSWALK_VALUE
                                                                : mark_label[best_slot];
            ans.slot     = 6'(best_slot);
        end
        return ans;
    endfunction

    function automatic t_landmark_item make_item(input logic req, input int slot,
                                                 input logic [1:0] kind, input logic enable,
                                                 input logic [1:0] label, input int x,
                                                 input int y, input logic [15:0] heading);
        t_landmark_item it;
        it.req     = req;
        it.slot    = 6'(slot);
        it.kind    = kind;
        it.enable  = enable;
        it.label   = label;
        it.x       = 24'(x);
        it.y       = 24'(y);
        it.heading = heading;
        return it;
    endfunction

    // Transfer one item, with an optional idle burst first; valid stays high after
    task automatic send_item(input t_landmark_item it);
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.req;
        s_axis_tdata  <= {5'b0, it.heading, it.y, it.x, it.label, it.enable, it.kind,
                          it.slot};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        detector_answers.insert(detector_answers.size(), detect_landmark(it));
    endtask

    // Drop valid and wait until every predicted answer has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (detector_answers.size() != 0) @(posedge i_clk);
    endtask

    // Write both registers while the block is idle
    task automatic write_settings(input logic [15:0] la, input logic [22:0] maxd);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= ald_pkg::CFG_LOOK_AHEAD;
        i_cfg_data <= 23'(la);
        @(posedge i_clk);
        la_setting  = la;
        i_cfg_idx  <= ald_pkg::CFG_MAX_DIST;
        i_cfg_data <= maxd;
        @(posedge i_clk);
        maxd_setting = maxd;
        i_cfg_we    <= 1'b0;
    endtask

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch on %s: got %0d, want %0d (cycle %0d)", field, got, want,
                 cycle_count);
        mismatch_count++;
    endtask

    function automatic logic [1:0] pick_kind();
        int r;
        r = $urandom_range(0, 9);
        return (r < 3) ? ald_pkg::KIND_CROSSWALK : (r < 6) ? KIND_TURN
             : (r < 9) ? KIND_JUNCTION : KIND_SPARE;
    endfunction

    function automatic int clamp_coord(input longint v);
        if (v < COORD_MIN) return COORD_MIN;
        if (v > COORD_MAX) return COORD_MAX;
        return int'(v);
    endfunction

    function automatic int pick_center();
        case ($urandom_range(0, 5))
            0:       return COORD_MIN + int'($urandom_range(0, 4095));
            1:       return COORD_MAX - int'($urandom_range(0, 4095));
            default: return int'($urandom_range(0, 8388607)) - 4194304;
        endcase
    endfunction

    // Write every slot once so no query ever scans unwritten memory, then clear all
    task automatic test_table_fill();
        for (int s = 0; s < ald_pkg::TABLE_ENTRIES; s++) begin
            send_item(make_item(ald_pkg::REQ_LOAD, s, 2'($urandom), 1'b1, 2'($urandom),
                                int'($urandom), int'($urandom), 16'($urandom)));
        end
        for (int s = 0; s < ald_pkg::TABLE_ENTRIES; s++) begin
            send_item(make_item(ald_pkg::REQ_LOAD, s, 2'($urandom), 1'b0, 2'($urandom),
                                int'($urandom), int'($urandom), 16'($urandom)));
        end
    endtask

    // Hand-picked loads and queries at the reset settings
    task automatic test_directed();
        // empty table
        send_item(make_item(ald_pkg::REQ_QUERY, 0, ald_pkg::KIND_CROSSWALK, 1'b0, LABEL_NONE,
                            0, 0, HEAD_EAST));
        // crosswalk ahead, then behind
        send_item(make_item(ald_pkg::REQ_LOAD, 5, ald_pkg::KIND_CROSSWALK, 1'b1, LABEL_TWO,
                            768, 0, HEAD_EAST));
        send_item(make_item(ald_pkg::REQ_QUERY, 63, ald_pkg::KIND_CROSSWALK, 1'b1, LABEL_ODD,
                            0, 0, HEAD_EAST));
        send_item(make_item(ald_pkg::REQ_QUERY, 0, ald_pkg::KIND_CROSSWALK, 1'b0, LABEL_NONE,
                            0, 0, HEAD_WEST));
        // two turn points at one spot: lower slot wins
        send_item(make_item(ald_pkg::REQ_LOAD, 9, KIND_TURN, 1'b1, LABEL_TWO, 1024, 0,
                            HEAD_EAST));
        send_item(make_item(ald_pkg::REQ_LOAD, 3, KIND_TURN, 1'b1, LABEL_ONE, 1024, 0,
                            HEAD_EAST));
        send_item(make_item(ald_pkg::REQ_QUERY, 0, KIND_TURN, 1'b0, LABEL_NONE, 0, 0,
                            HEAD_EAST));
        // junction with label zero, then label three
        send_item(make_item(ald_pkg::REQ_LOAD, 1, KIND_JUNCTION, 1'b1, LABEL_NONE, 512, 256,
                            HEAD_EAST));
        send_item(make_item(ald_pkg::REQ_QUERY, 0, KIND_JUNCTION, 1'b0, LABEL_NONE, 0, 0,
                            HEAD_EAST));
        send_item(make_item(ald_pkg::REQ_LOAD, 1, KIND_JUNCTION, 1'b1, LABEL_ODD, 512, 256,
                            HEAD_EAST));
        send_item(make_item(ald_pkg::REQ_QUERY, 0, KIND_JUNCTION, 1'b0, LABEL_NONE, 0, 0,
                            HEAD_EAST));
        // kind three behaves as a labeled kind
        send_item(make_item(ald_pkg::REQ_LOAD, 63, KIND_SPARE, 1'b1, LABEL_TWO, 256, 256,
                            HEAD_EAST));
        send_item(make_item(ald_pkg::REQ_QUERY, 0, KIND_SPARE, 1'b0, LABEL_NONE, 0, 0,
                            HEAD_NE));
        // clear the near junction; the remaining one is beyond max distance
        send_item(make_item(ald_pkg::REQ_LOAD, 1, KIND_JUNCTION, 1'b0, LABEL_ODD, 512, 256,
                            HEAD_EAST));
        send_item(make_item(ald_pkg::REQ_LOAD, 20, KIND_JUNCTION, 1'b1, LABEL_ONE, 2560, 0,
                            HEAD_EAST));
        send_item(make_item(ald_pkg::REQ_QUERY, 0, KIND_JUNCTION, 1'b0, LABEL_NONE, 0, 0,
                            HEAD_EAST));
        // coordinate extremes
        send_item(make_item(ald_pkg::REQ_LOAD, 40, KIND_JUNCTION, 1'b1, LABEL_TWO, COORD_MAX,
                            COORD_MIN, 16'hFFFF));
        send_item(make_item(ald_pkg::REQ_QUERY, 0, KIND_JUNCTION, 1'b0, LABEL_NONE, COORD_MIN,
                            COORD_MAX, HEAD_SE));
        send_item(make_item(ald_pkg::REQ_QUERY, 0, KIND_JUNCTION, 1'b0, LABEL_NONE, COORD_MAX,
                            COORD_MIN, 16'hFFFF));
        // pose exactly on a landmark is never approached
        send_item(make_item(ald_pkg::REQ_QUERY, 0, KIND_TURN, 1'b0, LABEL_NONE, 1024, 0,
                            HEAD_NORTH));
    endtask

    // Register extremes against the directed table contents
    task automatic test_settings_extremes();
        write_settings(16'hFFFF, 23'h7FFFFF);
        send_item(make_item(ald_pkg::REQ_QUERY, 0, KIND_TURN, 1'b0, LABEL_NONE, 0, 0,
                            HEAD_EAST));
        send_item(make_item(ald_pkg::REQ_QUERY, 0, KIND_JUNCTION, 1'b0, LABEL_NONE, -4096, 0,
                            HEAD_EAST));
        send_item(make_item(ald_pkg::REQ_QUERY, 0, ald_pkg::KIND_CROSSWALK, 1'b0, LABEL_NONE,
                            0, 0, HEAD_WEST));
        write_settings(16'd0, 23'd0);
        send_item(make_item(ald_pkg::REQ_QUERY, 0, KIND_TURN, 1'b0, LABEL_NONE, 0, 0,
                            HEAD_EAST));
        send_item(make_item(ald_pkg::REQ_QUERY, 0, ald_pkg::KIND_CROSSWALK, 1'b0, LABEL_NONE,
                            0, 0, HEAD_EAST));
    endtask

    // Clustered loads and queries around a moving center, with some raw noise
    task automatic test_random_phase(input int count, input logic [15:0] la,
                                     input logic [22:0] maxd, input bit idling);
        int cx;
        int cy;
        int spread;
        int r;
        t_landmark_item it;
        write_settings(la, maxd);
        tx_idle_on  = idling;
        rx_stall_on = idling;
        cx = pick_center();
        cy = pick_center();
        spread = 2048;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 49) == 0) begin
                cx = pick_center();
                cy = pick_center();
            end
            r = $urandom_range(0, 99);
            it = make_item(ald_pkg::REQ_LOAD, $urandom_range(0, 63), pick_kind(),
                           $urandom_range(0, 9) != 0, 2'($urandom),
                           clamp_coord(longint'(cx) + $urandom_range(0, 2 * spread) - spread),
                           clamp_coord(longint'(cy) + $urandom_range(0, 2 * spread) - spread),
                           16'($urandom));
            if (r >= 35 && r < 85) begin
                it.req = ald_pkg::REQ_QUERY;
            end else if (r >= 85) begin
                it.req = 1'($urandom);
                it.x   = 24'($urandom);
                it.y   = 24'($urandom);
            end
            send_item(it);
            // pause the sender until the block has answered everything
            if ($urandom_range(0, 59) == 0) drain_results();
        end
    endtask

    // Receiver: random stall bursts while stalling is enabled
    always @(posedge i_clk) begin
        if (!rx_stall_on) begin
            stall_left    <= 0;
            m_axis_tready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left    <= $urandom_range(0, 4);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_landmark_answer want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (detector_answers.size() == 0) begin
                report_mismatch("unexpected result", int'(m_axis_tdata), -1);
            end else begin
                want = detector_answers.pop_front();
                if (m_axis_tuser !== want.detected)
                    report_mismatch("detected", int'(m_axis_tuser), int'(want.detected));
                if (m_axis_tdata[1:0] !== want.value)
                    report_mismatch("feature_value", int'(m_axis_tdata[1:0]), int'(want.value));
                if (m_axis_tdata[7:2] !== want.slot)
                    report_mismatch("match_slot", int'(m_axis_tdata[7:2]), int'(want.slot));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        fill_sine_rom();
        for (int s = 0; s < ald_pkg::TABLE_ENTRIES; s++) mark_valid[s] = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_table_fill();
        test_directed();
        test_settings_extremes();
        test_random_phase(100, 16'd256, 23'd2560, 1'b1);
        test_random_phase(80, 16'd0, 23'h7FFFFF, 1'b1);
        test_random_phase(100, 16'hFFFF, 23'd2048, 1'b1);
        test_random_phase(70, 16'd1, 23'd1, 1'b1);
        test_random_phase(120, 16'($urandom), 23'($urandom_range(0, 8388607)), 1'b1);
        // last part runs at full rate on both sides
        test_random_phase(130, 16'd384, 23'd1024, 1'b0);

        drain_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/ald_pkg.sv
rtl/ald_offset.sv
rtl/approaching_landmark_detector.sv
tb/tb_top.sv
